>>> src/acc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_pkg - shared types and codes of the alarm clock controller
// event and button codes, mode codes, display kinds and display helpers
// ----------------------------------------------------------------------------
package acc_pkg;

  typedef logic [1:0]  opcode_t;
  typedef logic [1:0]  button_t;
  typedef logic [2:0]  mode_t;
  typedef logic [2:0]  kind_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [3:0]  volume_t;
  typedef logic [11:0] dvalue_t;
  typedef logic [6:0]  rvolume_t;
  typedef logic [7:0]  seconds_t;

  typedef struct packed {
    kind_t   kind;
    dvalue_t value;
  } display_t;

  // event kinds
  localparam opcode_t OP_SECOND = 2'd0;
  localparam opcode_t OP_HALF   = 2'd1;
  localparam opcode_t OP_BUTTON = 2'd2;

  // buttons
  localparam button_t BTN_MODE  = 2'd0;
  localparam button_t BTN_PLUS  = 2'd1;
  localparam button_t BTN_MINUS = 2'd2;
  localparam button_t BTN_ALARM = 2'd3;

  // display modes
  localparam mode_t MODE_CLOCK    = 3'd0;
  localparam mode_t MODE_SHOW     = 3'd1;
  localparam mode_t MODE_SET_HOUR = 3'd2;
  localparam mode_t MODE_SET_MIN  = 3'd3;
  localparam mode_t MODE_SOUND    = 3'd4;
  localparam mode_t MODE_VOLUME   = 3'd5;

  // display kinds
  localparam kind_t KIND_BLANK      = 3'd0;
  localparam kind_t KIND_TIME_COLON = 3'd1;
  localparam kind_t KIND_TIME_PLAIN = 3'd2;
  localparam kind_t KIND_SET_HOUR   = 3'd3;
  localparam kind_t KIND_SET_MIN    = 3'd4;
  localparam kind_t KIND_SOUND      = 3'd5;
  localparam kind_t KIND_VOLUME     = 3'd6;

  localparam hour_t    HOUR_MAX       = 5'd23;
  localparam minute_t  MINUTE_MAX     = 6'd59;
  localparam volume_t  VOLUME_MAX     = 4'd9;
  localparam seconds_t IDLE_MAX       = 8'd255;
  localparam seconds_t TIMEOUT_RESET  = 8'd15;

  // hour * 100 + minute, kept to the display width
  function automatic dvalue_t hhmm(input hour_t h, input minute_t m);
    dvalue_t prod;
    prod = dvalue_t'({7'd0, h} * 12'd100);
    return prod + {6'd0, m};
  endfunction

  // what a mode shows; clock mode has no display of its own
  function automatic display_t mode_display(input mode_t mode, input hour_t ah,
                                            input minute_t am, input volume_t vol);
    display_t d;
    d.kind  = KIND_BLANK;
    d.value = '0;
    case (mode)
      MODE_SHOW: begin
        d.kind  = KIND_TIME_COLON;
        d.value = hhmm(ah, am);
      end
      MODE_SET_HOUR: begin
        d.kind  = KIND_SET_HOUR;
        d.value = {7'd0, ah};
      end
      MODE_SET_MIN: begin
        d.kind  = KIND_SET_MIN;
        d.value = {6'd0, am};
      end
      MODE_SOUND: begin
        d.kind  = KIND_SOUND;
        d.value = '0;
      end
      MODE_VOLUME: begin
        d.kind  = KIND_VOLUME;
        d.value = {8'd0, vol};
      end
      default: begin
        d.kind  = KIND_BLANK;
        d.value = '0;
      end
    endcase
    return d;
  endfunction

endpackage

>>> src/acc_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_evt_if - event channel of the alarm clock controller
// valid/ready handshake carrying one event item
// ----------------------------------------------------------------------------
interface acc_evt_if;
  import acc_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  button_t button;
  hour_t   now_hour;
  minute_t now_minute;
  minute_t now_second;

  modport source (output valid, output opcode, output button, output now_hour,
                  output now_minute, output now_second, input ready);
  modport sink   (input valid, input opcode, input button, input now_hour,
                  input now_minute, input now_second, output ready);
endinterface

>>> src/acc_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_res_if - result channel of the alarm clock controller
// valid/ready handshake carrying one result item
// ----------------------------------------------------------------------------
interface acc_res_if;
  import acc_pkg::*;

  logic     valid;
  logic     ready;
  kind_t    display_kind;
  dvalue_t  display_value;
  logic     ring;
  rvolume_t ring_volume;
  logic     alarm_enabled;
  mode_t    mode_now;

  modport source (output valid, output display_kind, output display_value, output ring,
                  output ring_volume, output alarm_enabled, output mode_now, input ready);
  modport sink   (input valid, input display_kind, input display_value, input ring,
                  input ring_volume, input alarm_enabled, input mode_now, output ready);
endinterface

>>> src/alarm_clock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_controller - mode controller of a digital alarm clock
// display mode, alarm time and volume, blink flags and back-to-clock timeout
// ----------------------------------------------------------------------------
// usage
//   evt : one item per event (second tick, half-second tick, button press),
//         each carrying the current time
//   res : exactly one item per event: display kind and value after the event,
//         ring flag with volume, alarm enable and current mode
//   cfg_wr_en / cfg_wr_data : back-to-clock timeout in second ticks, written
//         while the block is idle; 0 behaves as 1
// timing
//   an accepted event passes an input register, then the state update and
//   result register, whose output drives res.valid; one item per cycle
//   sustained while res is not stalled, because the state update is a single
//   short pass of logic per event
// reset (synchronous, rst high)
//   clock mode, alarm 00:00 off, volume 0, blink flags and timeout cleared,
//   shown display blank; timeout register back to 15 seconds
// stalls
//   while res is stalled the held result stays put; the input register still
//   takes one more event, then evt.ready drops until the result leaves
// ----------------------------------------------------------------------------
module alarm_clock_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  acc_pkg::seconds_t cfg_wr_data,
  acc_evt_if.sink         evt,
  acc_res_if.source       res
);
  import acc_pkg::*;

  // configuration
  seconds_t timeout_cfg;

  // input register
  logic    s1_valid;
  opcode_t s1_opcode;
  button_t s1_button;
  hour_t   s1_hour;
  minute_t s1_minute;
  minute_t s1_second;

  // controller state
  logic [2:0] mode;
  hour_t      alarm_hour;
  minute_t    alarm_minute;
  logic       alarm_on;
  volume_t    alarm_volume;
  logic       colon_blink;
  logic       half_blink;
  seconds_t   idle_seconds;
  logic       timeout_armed;
  display_t   shown;

  // next values
  logic [2:0] mode_next;
  hour_t      alarm_hour_next;
  minute_t    alarm_minute_next;
  logic       alarm_on_next;
  volume_t    alarm_volume_next;
  logic       colon_blink_next;
  logic       half_blink_next;
  seconds_t   idle_seconds_next;
  logic       timeout_armed_next;
  display_t   shown_next;
  logic       ring_next;
  rvolume_t   ring_volume_next;

  logic       clock_show;    // clock display and colon toggle on this event
  logic       alarm_check;   // alarm compare on this event
  logic [6:0] vol_times_ten;

  // result register
  logic res_valid;
  logic advance;

  // the input register moves on when the result register is free or drains
  assign advance   = s1_valid && (!res_valid || res.ready);
  assign evt.ready = !s1_valid || advance;
  assign res.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_cfg <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_cfg <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_opcode <= evt.opcode;
      s1_button <= evt.button;
      s1_hour   <= evt.now_hour;
      s1_minute <= evt.now_minute;
      s1_second <= evt.now_second;
    end
  end

  // one pass of the mode machine per event
  always_comb begin
    mode_next          = mode;
    alarm_hour_next    = alarm_hour;
    alarm_minute_next  = alarm_minute;
    alarm_on_next      = alarm_on;
    alarm_volume_next  = alarm_volume;
    colon_blink_next   = colon_blink;
    half_blink_next    = half_blink;
    idle_seconds_next  = idle_seconds;
    timeout_armed_next = timeout_armed;
    shown_next         = shown;
    ring_next          = 1'b0;
    clock_show         = 1'b0;
    alarm_check        = 1'b0;

    case (s1_opcode)
      OP_SECOND: begin
        if (timeout_armed) begin
          idle_seconds_next = (idle_seconds == IDLE_MAX) ? idle_seconds
                                                         : idle_seconds + 8'd1;
          // a zero timeout still fires here since the count is at least one
          if (idle_seconds_next >= timeout_cfg) begin
            mode_next          = MODE_CLOCK;
            timeout_armed_next = 1'b0;
          end
        end
        clock_show  = (mode_next == MODE_CLOCK);
        alarm_check = 1'b1;
      end

      OP_HALF: begin
        half_blink_next = ~half_blink;
        if (mode inside {MODE_SHOW, MODE_SET_HOUR, MODE_SET_MIN}) begin
          if (half_blink_next) begin
            shown_next.kind  = KIND_BLANK;
            shown_next.value = '0;
          end else begin
            shown_next = mode_display(mode, alarm_hour, alarm_minute, alarm_volume);
          end
        end
      end

      OP_BUTTON: begin
        if (s1_button == BTN_ALARM) begin
          alarm_on_next = ~alarm_on;
        end else begin
          timeout_armed_next = 1'b1;
          idle_seconds_next  = '0;
        end

        case (mode)
          MODE_CLOCK: begin
            if (s1_button == BTN_MODE) mode_next = MODE_SHOW;
          end
          MODE_SHOW: begin
            if (s1_button == BTN_MODE) mode_next = MODE_SET_HOUR;
          end
          MODE_SET_HOUR: begin
            if (s1_button == BTN_PLUS) begin
              alarm_hour_next = (alarm_hour >= HOUR_MAX) ? '0 : alarm_hour + 5'd1;
            end
            if (s1_button == BTN_MINUS) begin
              alarm_hour_next = (alarm_hour == '0 || alarm_hour > HOUR_MAX) ? HOUR_MAX
                                                                             : alarm_hour - 5'd1;
            end
            if (s1_button == BTN_MODE) mode_next = MODE_SET_MIN;
          end
          MODE_SET_MIN: begin
            if (s1_button == BTN_PLUS) begin
              alarm_minute_next = (alarm_minute >= MINUTE_MAX) ? '0 : alarm_minute + 6'd1;
            end
            if (s1_button == BTN_MINUS) begin
              alarm_minute_next = (alarm_minute == '0 || alarm_minute > MINUTE_MAX)
                                  ? MINUTE_MAX : alarm_minute - 6'd1;
            end
            if (s1_button == BTN_MODE) mode_next = MODE_SOUND;
          end
          MODE_SOUND: begin
            if (s1_button == BTN_MODE) mode_next = MODE_VOLUME;
          end
          MODE_VOLUME: begin
            if (s1_button == BTN_PLUS) begin
              alarm_volume_next = (alarm_volume >= VOLUME_MAX) ? VOLUME_MAX
                                                               : alarm_volume + 4'd1;
            end
            if (s1_button == BTN_MINUS) begin
              alarm_volume_next = (alarm_volume == '0) ? '0 : alarm_volume - 4'd1;
            end
            // leaving volume mode behaves like a second tick in clock mode
            if (s1_button == BTN_MODE) begin
              mode_next   = MODE_CLOCK;
              clock_show  = 1'b1;
              alarm_check = 1'b1;
            end
          end
          default: begin
            mode_next = MODE_CLOCK;
          end
        endcase

        // the settled mode's display wins over anything shown on the way
        if (mode_next != MODE_CLOCK) begin
          shown_next = mode_display(mode_next, alarm_hour_next, alarm_minute_next,
                                    alarm_volume_next);
        end
      end

      default: begin
      end
    endcase

    if (clock_show) begin
      shown_next.kind  = colon_blink ? KIND_TIME_COLON : KIND_TIME_PLAIN;
      shown_next.value = hhmm(s1_hour, s1_minute);
      colon_blink_next = ~colon_blink;
    end

    // alarm fires only at second zero of the matching minute
    if (alarm_check && s1_second == '0 && alarm_on_next &&
        alarm_hour_next == s1_hour && alarm_minute_next == s1_minute) begin
      ring_next = 1'b1;
      mode_next = MODE_CLOCK;
    end
  end

  // volume times ten as two shifts
  assign vol_times_ten    = {alarm_volume_next, 3'd0} + {2'd0, alarm_volume_next, 1'b0};
  assign ring_volume_next = ring_next ? vol_times_ten : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_CLOCK;
      alarm_hour    <= '0;
      alarm_minute  <= '0;
      alarm_on      <= 1'b0;
      alarm_volume  <= '0;
      colon_blink   <= 1'b0;
      half_blink    <= 1'b0;
      idle_seconds  <= '0;
      timeout_armed <= 1'b0;
      shown         <= '0;
    end else if (advance) begin
      mode          <= mode_next;
      alarm_hour    <= alarm_hour_next;
      alarm_minute  <= alarm_minute_next;
      alarm_on      <= alarm_on_next;
      alarm_volume  <= alarm_volume_next;
      colon_blink   <= colon_blink_next;
      half_blink    <= half_blink_next;
      idle_seconds  <= idle_seconds_next;
      timeout_armed <= timeout_armed_next;
      shown         <= shown_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.display_kind  <= shown_next.kind;
      res.display_value <= shown_next.value;
      res.ring          <= ring_next;
      res.ring_volume   <= ring_volume_next;
      res.alarm_enabled <= alarm_on_next;
      res.mode_now      <= mode_next;
    end
  end

endmodule
